### sv/ljpef_pkg.sv
package ljpef_pkg;

	// field widths
	localparam int POS_W = 32;
	localparam int IDX_W = 10;
	localparam int CFG_W = 32;
	localparam int RES_W = 64;
	localparam int DIF_W = POS_W + 1;
	localparam int SQ_W  = 2 * DIF_W;
	localparam int R_W   = SQ_W;
	localparam int Q_W   = 2 * CFG_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIGMA = 1'b0,
		REG_EPS   = 1'b1
	} reg_idx_t;

	localparam logic [CFG_W-1:0] SIGMA_RESET = 32'h0001_0000;
	localparam logic [CFG_W-1:0] EPS_RESET   = 32'h0001_0000;

	// wide arithmetic
	localparam int MUL_W  = 512;
	localparam int MUL_BW = 66;
	localparam int MUL_CH = 22;
	localparam int DIV_DW = 480;
	localparam int DIV_QW = 63;

	// stream words
	localparam int IN_TW   = 216;
	localparam int OUT_TW  = 280;
	localparam int OUT_UW  = 2;

	typedef struct packed {
		logic [IDX_W-1:0]          idx1;
		logic [IDX_W-1:0]          idx2;
		logic                      zero;
		logic [2:0]                dneg;
		logic [2:0][DIF_W-1:0]     dmag;
		logic                      eneg;
		logic                      gneg;
		logic [CFG_W-1:0]          eps;
		logic [R_W-1:0]            r;
		logic [Q_W-1:0]            q;
	} side_t;

endpackage

### sv/ljpef_mul.sv
module ljpef_mul (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ljpef_pkg::MUL_W-1:0]  a,
	input  logic [ljpef_pkg::MUL_BW-1:0] b,
	output logic [ljpef_pkg::MUL_W-1:0]  p
);
	import ljpef_pkg::*;

	localparam int PW     = MUL_W + MUL_CH;
	localparam int LIMB   = 32;
	localparam int LIMB_N = MUL_W / LIMB;
	localparam int LP_W   = LIMB + MUL_CH;

	logic [MUL_W-1:0]        a_s1, a_s2;
	logic [MUL_BW-MUL_CH-1:0]   b_s1;
	logic [MUL_CH-1:0]       b_s2;
	logic [MUL_W-1:0]        acc_s1, acc_s2, acc_s3;
	logic [PW-1:0]           pp0, pp1, pp2;

	// a times one 22-bit slice, built from 32x22 limb products
	// even and odd limbs land in two non-overlapping rows, then one add
	function automatic logic [PW-1:0] slice_mul(input logic [MUL_W-1:0] x,
		input logic [MUL_CH-1:0] y);
		logic [PW-1:0]   ev, od;
		logic [LP_W-1:0] pr;
		ev = '0;
		od = '0;
		for (int i = 0; i < LIMB_N; i++) begin
			pr = {{MUL_CH{1'b0}}, x[i*LIMB +: LIMB]} * {{LIMB{1'b0}}, y};
			if (i[0])
				od[i*LIMB +: LP_W] = pr;
			else
				ev[i*LIMB +: LP_W] = pr;
		end
		return ev + od;
	endfunction

	// one 22-bit slice of b per stage
	assign pp0 = slice_mul(a, b[MUL_CH-1:0]);
	assign pp1 = slice_mul(a_s1, b_s1[MUL_CH-1:0]);
	assign pp2 = slice_mul(a_s2, b_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a;
			b_s1   <= b[MUL_BW-1:MUL_CH];
			acc_s1 <= pp0[MUL_W-1:0];
			a_s2   <= a_s1;
			b_s2   <= b_s1[MUL_BW-MUL_CH-1:MUL_CH];
			acc_s2 <= acc_s1 + {pp1[MUL_W-MUL_CH-1:0], {MUL_CH{1'b0}}};
			acc_s3 <= acc_s2 + {pp2[MUL_W-2*MUL_CH-1:0], {(2*MUL_CH){1'b0}}};
		end
	end

	assign p = acc_s3;

endmodule

### sv/ljpef_div.sv
module ljpef_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ljpef_pkg::MUL_W-1:0]  num,
	input  logic [ljpef_pkg::DIV_DW-1:0] den,
	output logic [ljpef_pkg::DIV_QW-1:0] quo,
	output logic                        over
);
	import ljpef_pkg::*;

	localparam int HW = MUL_W - DIV_QW;

	logic [DIV_DW-1:0] rem_s [0:DIV_QW-1];
	logic [DIV_DW-1:0] den_s [0:DIV_QW-1];
	logic [DIV_QW-1:0] lo_s  [0:DIV_QW-1];
	logic [DIV_QW-1:0] q_s   [0:DIV_QW];
	logic              ov_s  [0:DIV_QW];
	logic [DIV_DW-1:0] head;
	logic              ov0;

	// quotient of 2^63 or more means clamp
	assign head = {{(DIV_DW-HW){1'b0}}, num[MUL_W-1:DIV_QW]};
	assign ov0  = head >= den;

	always_ff @(posedge clk) begin
		if (en) begin
			ov_s[0]  <= ov0;
			rem_s[0] <= ov0 ? '0 : head;
			den_s[0] <= den;
			lo_s[0]  <= num[DIV_QW-1:0];
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
		logic [DIV_DW:0] t;
		logic [DIV_DW:0] d;
		logic            ge;
		assign t  = {rem_s[k-1], lo_s[k-1][DIV_QW-1]};
		assign d  = t - {1'b0, den_s[k-1]};
		// t stays below twice den, so the top bit of d is the borrow
		assign ge = !d[DIV_DW];
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k]  <= {q_s[k-1][DIV_QW-2:0], ge};
				ov_s[k] <= ov_s[k-1];
			end
		end
		if (k < DIV_QW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? d[DIV_DW-1:0] : t[DIV_DW-1:0];
					den_s[k] <= den_s[k-1];
					lo_s[k]  <= {lo_s[k-1][DIV_QW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo  = q_s[DIV_QW];
	assign over = ov_s[DIV_QW];

endmodule

### sv/lj_pair_energy_force.sv
// lennard-jones 12-6 pair evaluator. one particle pair per word goes in, one result word
// comes out per pair, in order. a new pair is taken every cycle unless the output stalls;
// a pair's result passes through the chain of wide multipliers (seven products of
// three stages each) followed by the 64-stage restoring divider. a stall on the output
// freezes the whole pipeline, so nothing is dropped or repeated. results are exact:
// energy = 4*eps*(lj6^2 - lj6) and gradient on the first particle, truncated toward zero
// to q32.32 and clamped symmetrically to +/-(2^63-1) with the saturated flag. coincident
// particles give zeros and zero_distance. sigma and epsilon are latched per pair as it
// enters, so they may only be rewritten while no pair is in flight.
module lj_pair_energy_force (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [ljpef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ljpef_pkg::CFG_W-1:0]   cfg_data,
	// input pairs
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, first_index, second_index
	input  logic [ljpef_pkg::IN_TW-1:0]   s_tdata,
	// results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pair_energy, grad_x, grad_y, grad_z, out_first_index, out_second_index
	output logic [ljpef_pkg::OUT_TW-1:0]  m_tdata,
	// saturated, zero_distance
	output logic [ljpef_pkg::OUT_UW-1:0]  m_tuser
);
	import ljpef_pkg::*;

	// stage numbers along the pipe
	localparam int ST_SIDE = 3;
	localparam int ST_T    = 19;
	localparam int ST_M7   = 22;
	localparam int ST_DG   = 25;
	localparam int ST_EQ   = 86;
	localparam int LAT     = 89;
	localparam logic [RES_W-1:0] MAG_MAX = {1'b0, {(RES_W-1){1'b1}}};

	logic [CFG_W-1:0] sigma_q, eps_q;
	logic             adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
			eps_q   <= EPS_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SIGMA: sigma_q <= cfg_data;
				REG_EPS:   eps_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// whole pipe moves when the output register is free or being emptied
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic vld_s [1:LAT];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) vld_s[k] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= LAT; k++) vld_s[k] <= vld_s[k-1];
			m_tvalid <= vld_s[LAT];
		end
	end

	// s1: per-axis separation, 33 bits exact
	logic signed [DIF_W-1:0] d_s1 [3];
	logic [IDX_W-1:0]        idx1_s1, idx2_s1;
	logic [CFG_W-1:0]        sig_s1, eps_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				d_s1[a] <= $signed({s_tdata[a*POS_W+POS_W-1], s_tdata[a*POS_W +: POS_W]})
					- $signed({s_tdata[(a+3)*POS_W+POS_W-1], s_tdata[(a+3)*POS_W +: POS_W]});
			end
			idx1_s1 <= s_tdata[6*POS_W +: IDX_W];
			idx2_s1 <= s_tdata[6*POS_W+IDX_W +: IDX_W];
			sig_s1  <= sigma_q;
			eps_s1  <= eps_q;
		end
	end

	// s2: magnitudes squared, sigma squared
	logic [2:0][DIF_W-1:0]   mag_c;
	logic [2:0][DIF_W-1:0]   dmag_s2;
	logic [2:0]              dneg_s2;
	logic [SQ_W-1:0]         sq_s2 [3];
	logic [Q_W-1:0]          q_s2;
	logic [IDX_W-1:0]        idx1_s2, idx2_s2;
	logic [CFG_W-1:0]        eps_s2;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag_c[a] = d_s1[a][DIF_W-1] ? DIF_W'(-d_s1[a]) : DIF_W'(d_s1[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				dmag_s2[a] <= mag_c[a];
				dneg_s2[a] <= d_s1[a][DIF_W-1];
				sq_s2[a]   <= {{DIF_W{1'b0}}, mag_c[a]} * {{DIF_W{1'b0}}, mag_c[a]};
			end
			q_s2    <= {{CFG_W{1'b0}}, sig_s1} * {{CFG_W{1'b0}}, sig_s1};
			idx1_s2 <= idx1_s1;
			idx2_s2 <= idx2_s1;
			eps_s2  <= eps_s1;
		end
	end

	// s3 onward: side information travels with the pair
	side_t           side_s [ST_SIDE:LAT];
	side_t           side_t_c;
	logic [R_W-1:0]  r_c;
	logic            eneg_c, gneg_c;

	assign r_c = sq_s2[0] + sq_s2[1] + sq_s2[2];

	// signs of the two differences join the side word on entry to s19
	always_comb begin
		side_t_c      = side_s[ST_T-1];
		side_t_c.eneg = eneg_c;
		side_t_c.gneg = gneg_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[ST_SIDE].idx1 <= idx1_s2;
			side_s[ST_SIDE].idx2 <= idx2_s2;
			side_s[ST_SIDE].zero <= r_c == '0;
			side_s[ST_SIDE].dneg <= dneg_s2;
			side_s[ST_SIDE].dmag <= dmag_s2;
			side_s[ST_SIDE].eneg <= 1'b0;
			side_s[ST_SIDE].gneg <= 1'b0;
			side_s[ST_SIDE].eps  <= eps_s2;
			side_s[ST_SIDE].r    <= r_c;
			side_s[ST_SIDE].q    <= q_s2;
			for (int k = ST_SIDE + 1; k <= LAT; k++) begin
				if (k == ST_T)
					side_s[k] <= side_t_c;
				else
					side_s[k] <= side_s[k-1];
			end
		end
	end

	// power chains (m1 to m5 and r^7): each product multiplies by r or q only
	logic [MUL_W-1:0] r2_p, q2_p, r3_p, q3_p, q4_p, x1_p, r4_p;
	logic [MUL_W-1:0] q5_p, x2_p, r5_p, q6_p, x3_p, r6_p;
	logic [MUL_W-1:0] ne_p, pg_p, r7_p;
	logic [MUL_W-1:0] ng_p [3];

	function automatic logic [MUL_W-1:0] wide_r(input logic [R_W-1:0] v);
		return {{(MUL_W-R_W){1'b0}}, v};
	endfunction
	function automatic logic [MUL_BW-1:0] bq(input logic [Q_W-1:0] v);
		return {{(MUL_BW-Q_W){1'b0}}, v};
	endfunction

	// m1 (s3 -> s6)
	ljpef_mul u_r2 (.clk, .en(adv), .a(wide_r(side_s[3].r)), .b(side_s[3].r), .p(r2_p));
	ljpef_mul u_q2 (.clk, .en(adv), .a({{(MUL_W-Q_W){1'b0}}, side_s[3].q}),
		.b(bq(side_s[3].q)), .p(q2_p));
	// m2 (s6 -> s9)
	ljpef_mul u_r3 (.clk, .en(adv), .a(r2_p), .b(side_s[6].r), .p(r3_p));
	ljpef_mul u_q3 (.clk, .en(adv), .a(q2_p), .b(bq(side_s[6].q)), .p(q3_p));
	// m3 (s9 -> s12)
	ljpef_mul u_q4 (.clk, .en(adv), .a(q3_p), .b(bq(side_s[9].q)), .p(q4_p));
	ljpef_mul u_x1 (.clk, .en(adv), .a(r3_p), .b(bq(side_s[9].q)), .p(x1_p));
	ljpef_mul u_r4 (.clk, .en(adv), .a(r3_p), .b(side_s[9].r), .p(r4_p));
	// m4 (s12 -> s15)
	ljpef_mul u_q5 (.clk, .en(adv), .a(q4_p), .b(bq(side_s[12].q)), .p(q5_p));
	ljpef_mul u_x2 (.clk, .en(adv), .a(x1_p), .b(bq(side_s[12].q)), .p(x2_p));
	ljpef_mul u_r5 (.clk, .en(adv), .a(r4_p), .b(side_s[12].r), .p(r5_p));
	// m5 (s15 -> s18): q^6, q^3*r^3, r^6
	ljpef_mul u_q6 (.clk, .en(adv), .a(q5_p), .b(bq(side_s[15].q)), .p(q6_p));
	ljpef_mul u_x3 (.clk, .en(adv), .a(x2_p), .b(bq(side_s[15].q)), .p(x3_p));
	ljpef_mul u_r6 (.clk, .en(adv), .a(r5_p), .b(side_s[15].r), .p(r6_p));

	// s19: signed differences q^3*(q^3 - r^3) and q^3*(2q^3 - r^3) as sign and magnitude
	logic [MUL_W-1:0] q6x2_c;
	logic [MUL_W-1:0] te_s19, tg_s19, r6_s19;

	assign q6x2_c = {q6_p[MUL_W-2:0], 1'b0};
	assign eneg_c = q6_p < x3_p;
	assign gneg_c = q6x2_c < x3_p;

	always_ff @(posedge clk) begin
		if (adv) begin
			te_s19 <= eneg_c ? x3_p - q6_p : q6_p - x3_p;
			tg_s19 <= gneg_c ? x3_p - q6x2_c : q6x2_c - x3_p;
			r6_s19 <= r6_p;
		end
	end

	// m6 (s19 -> s22): energy numerator (eps * 2^18), eps * gradient term, r^7
	ljpef_mul u_ne (.clk, .en(adv), .a(te_s19),
		.b({{(MUL_BW-CFG_W-18){1'b0}}, side_s[ST_T].eps, 18'b0}), .p(ne_p));
	ljpef_mul u_pg (.clk, .en(adv), .a(tg_s19),
		.b({{(MUL_BW-CFG_W){1'b0}}, side_s[ST_T].eps}), .p(pg_p));
	ljpef_mul u_r7 (.clk, .en(adv), .a(r6_s19), .b(side_s[ST_T].r), .p(r7_p));

	logic [MUL_W-1:0] r6_d [ST_T+1:ST_M7];
	logic [MUL_W-1:0] r7_d [ST_M7+1:ST_DG];
	always_ff @(posedge clk) begin
		if (adv) begin
			r6_d[ST_T+1] <= r6_s19;
			for (int k = ST_T + 2; k <= ST_M7; k++) r6_d[k] <= r6_d[k-1];
			r7_d[ST_M7+1] <= r7_p;
			for (int k = ST_M7 + 2; k <= ST_DG; k++) r7_d[k] <= r7_d[k-1];
		end
	end

	// m7 (s22 -> s25): times 24 * 2^32 and the axis magnitude
	logic [MUL_W-1:0] pg24_c;
	assign pg24_c = {pg_p[MUL_W-37:0], 36'b0} + {pg_p[MUL_W-36:0], 35'b0};

	for (genvar a = 0; a < 3; a++) begin : g_axis
		ljpef_mul u_ng (.clk, .en(adv), .a(pg24_c),
			.b({{(MUL_BW-DIF_W){1'b0}}, side_s[ST_M7].dmag[a]}), .p(ng_p[a]));
	end

	// dividers: energy by r^6 from s22 (lands at s86), gradients by r^7 from s25 (lands at s89)
	logic [DIV_QW-1:0] eq_q, gq_q [3];
	logic              eov, gov [3];

	ljpef_div u_dive (.clk, .en(adv), .num(ne_p), .den(r6_d[ST_M7][DIV_DW-1:0]),
		.quo(eq_q), .over(eov));
	for (genvar a = 0; a < 3; a++) begin : g_div
		ljpef_div u_divg (.clk, .en(adv), .num(ng_p[a]), .den(r7_d[ST_DG][DIV_DW-1:0]),
			.quo(gq_q[a]), .over(gov[a]));
	end

	// energy quotient waits for the gradients
	logic [DIV_QW-1:0] eq_d  [ST_EQ+1:LAT];
	logic              eov_d [ST_EQ+1:LAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			eq_d[ST_EQ+1]  <= eq_q;
			eov_d[ST_EQ+1] <= eov;
			for (int k = ST_EQ + 2; k <= LAT; k++) begin
				eq_d[k]  <= eq_d[k-1];
				eov_d[k] <= eov_d[k-1];
			end
		end
	end

	// output register: clamp, sign, zero-distance masking
	function automatic logic [RES_W-1:0] finish(input logic [DIV_QW-1:0] q,
		input logic ov, input logic neg);
		logic [RES_W-1:0] mag;
		mag = ov ? MAG_MAX : {1'b0, q};
		return neg ? RES_W'(-mag) : mag;
	endfunction

	side_t            sd;
	logic [RES_W-1:0] en_c;
	logic [RES_W-1:0] g_c [3];
	logic             sat_c;

	assign sd = side_s[LAT];

	always_comb begin
		en_c  = finish(eq_d[LAT], eov_d[LAT], sd.eneg);
		sat_c = eov_d[LAT];
		for (int a = 0; a < 3; a++) begin
			g_c[a] = finish(gq_q[a], gov[a], sd.dneg[a] == sd.gneg);
			sat_c  = sat_c | gov[a];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata[RES_W-1:0]         <= sd.zero ? '0 : en_c;
			m_tdata[2*RES_W-1:RES_W]   <= sd.zero ? '0 : g_c[0];
			m_tdata[3*RES_W-1:2*RES_W] <= sd.zero ? '0 : g_c[1];
			m_tdata[4*RES_W-1:3*RES_W] <= sd.zero ? '0 : g_c[2];
			m_tdata[4*RES_W +: IDX_W]       <= sd.idx1;
			m_tdata[4*RES_W+IDX_W +: IDX_W] <= sd.idx2;
			m_tdata[OUT_TW-1:4*RES_W+2*IDX_W] <= '0;
			m_tuser[0] <= sat_c & !sd.zero;
			m_tuser[1] <= sd.zero;
		end
	end

endmodule

### sv/ljpef_checker.sv
module ljpef_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ljpef_pkg::OUT_TW-1:0]  m_tdata,
	input logic [ljpef_pkg::OUT_UW-1:0]  m_tuser
);
	import ljpef_pkg::*;

	// a held result word does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// an empty output never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// coincident particles give zero results and no clamp
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[4*RES_W-1:0] == '0 && !m_tuser[0])
		else $error("zero distance word not cleared");

	// the input is only held back by a result word waiting at the output
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled without pending result");

endmodule

bind lj_pair_energy_force ljpef_checker u_ljpef_checker (.*);
